### src/gas_sensor_r0_calibrator_top_assert.svh
// Assertion macros for the gas sensor R0 calibrator.
// Used by gas_sensor_r0_calibrator_top; expects clk and rst in scope.
`ifndef GAS_SENSOR_R0_CALIBRATOR_TOP_ASSERT_SVH
`define GAS_SENSOR_R0_CALIBRATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GSR0_ASSERT_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gsr0 assertion failed");
// next-cycle implication
`define GSR0_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gsr0 assertion failed");
`else
`define GSR0_ASSERT_HOLDS(lbl, ante, cons)
`define GSR0_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### src/gsr0_pkg.sv
// Shared types, codes and constants for the gas sensor R0 calibrator.
// No dependencies.
`default_nettype none

package gsr0_pkg;

  // input modes
  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_SAMPLE = 2'd1;
  localparam logic [1:0] MODE_LOAD   = 2'd2;

  // result status codes
  localparam logic [2:0] STAT_STARTED  = 3'd0;
  localparam logic [2:0] STAT_BUSY     = 3'd1;
  localparam logic [2:0] STAT_TAKEN    = 3'd2;
  localparam logic [2:0] STAT_IGNORED  = 3'd3;
  localparam logic [2:0] STAT_CAL      = 3'd4;
  localparam logic [2:0] STAT_OOR      = 3'd5;
  localparam logic [2:0] STAT_LOADED   = 3'd6;
  localparam logic [2:0] STAT_DEFAULT  = 3'd7;

  // classified commands
  localparam logic [2:0] OP_START    = 3'd0;
  localparam logic [2:0] OP_SAMPLE   = 3'd1;
  localparam logic [2:0] OP_LOAD     = 3'd2;
  localparam logic [2:0] OP_LOAD_DEF = 3'd3;
  localparam logic [2:0] OP_NOP      = 3'd4;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY_MV    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_RES     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_R0_MIN       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_R0_MAX       = 3'd5;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] R0_DEFAULT_Q88 = 16'd2560;
  localparam logic [11:0] AVG_MAX_MV     = 12'd3300;
  localparam logic [11:0] AVG_MIN_MV     = 12'd10;

  // divider passes, two quotient bits each
  localparam logic [3:0] AVG_DIV_STEPS = 4'd10;  // 20-bit sum
  localparam logic [3:0] RS_DIV_STEPS  = 4'd15;  // 29-bit product
  localparam logic [3:0] R0_DIV_STEPS  = 4'd12;  // 24-bit rs*256

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] sample_mv;
    logic [15:0] stored_r0_q88;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] r0_q88;
    logic [11:0] avg_mv;
  } out_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [11:0] sample_mv;
    logic [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  sample_count;
    logic [12:0] supply_mv;
    logic [15:0] load_res_q88;
    logic [15:0] clean_air_ratio_q88;
    logic [15:0] r0_min_q88;
    logic [15:0] r0_max_q88;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;  // left-aligned to 2*steps bits
    logic [15:0] divisor;
    logic [3:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

  function automatic logic [15:0] sat16(input logic [31:0] v);
    sat16 = (v[31:16] != 16'd0) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

`default_nettype wire

### src/gsr0_div.sv
// Iterative restoring divider, two quotient bits per cycle.
// Depends on gsr0_pkg.
`default_nettype none

module gsr0_div (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire gsr0_pkg::div_req_t   req,
  output gsr0_pkg::div_rsp_t        rsp
);

  logic        busy;
  logic        done;
  logic [3:0]  cnt;
  logic [31:0] dvd;
  logic [15:0] rem;
  logic [31:0] quo;
  logic [15:0] dsr;

  logic [16:0] r_a, r_b;
  logic        ge_a, ge_b;
  logic [15:0] rem_a, rem_b;

  always_comb begin
    r_a   = {rem, dvd[31]};
    ge_a  = r_a >= {1'b0, dsr};
    rem_a = ge_a ? 16'(r_a - {1'b0, dsr}) : r_a[15:0];
    r_b   = {rem_a, dvd[30]};
    ge_b  = r_b >= {1'b0, dsr};
    rem_b = ge_b ? 16'(r_b - {1'b0, dsr}) : r_b[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // pulses for one cycle after the last pass
      done <= !req.start && busy && (cnt == 4'd1);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
        dvd  <= req.dividend;
        rem  <= 16'd0;
        quo  <= 32'd0;
        dsr  <= req.divisor;
      end else if (busy) begin
        dvd <= {dvd[29:0], 2'b00};
        rem <= rem_b;
        quo <= {quo[29:0], ge_a, ge_b};
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

### src/gsr0_front.sv
// Front end: input register that accepts and classifies items.
// Depends on gsr0_pkg; feeds gsr0_fifo.
`default_nettype none

module gsr0_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire gsr0_pkg::in_t in_data,
  input  wire logic          fifo_full,
  output logic               push,
  output gsr0_pkg::cmd_t     push_cmd
);

  logic           hold_valid;
  gsr0_pkg::cmd_t hold_cmd;
  gsr0_pkg::cmd_t cmd_next;

  always_comb begin
    cmd_next.sample_mv = in_data.sample_mv;
    cmd_next.value     = in_data.stored_r0_q88;
    unique case (in_data.mode)
      gsr0_pkg::MODE_START:  cmd_next.op = gsr0_pkg::OP_START;
      gsr0_pkg::MODE_SAMPLE: cmd_next.op = gsr0_pkg::OP_SAMPLE;
      gsr0_pkg::MODE_LOAD: begin
        if (in_data.stored_r0_q88 == 16'd0) begin
          cmd_next.op    = gsr0_pkg::OP_LOAD_DEF;
          cmd_next.value = gsr0_pkg::R0_DEFAULT_Q88;
        end else begin
          cmd_next.op = gsr0_pkg::OP_LOAD;
        end
      end
      default: cmd_next.op = gsr0_pkg::OP_NOP;
    endcase
  end

  assign push     = hold_valid && !fifo_full;
  assign in_ready = !hold_valid || !fifo_full;
  assign push_cmd = hold_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_cmd <= cmd_next;
    end
  end

endmodule

`default_nettype wire

### src/gsr0_fifo.sv
// Two-entry command queue between front and back end.
// Depends on gsr0_pkg.
`default_nettype none

module gsr0_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire gsr0_pkg::cmd_t  din,
  output logic                 full,
  input  wire logic            pop,
  output logic                 valid,
  output gsr0_pkg::cmd_t       dout
);

  gsr0_pkg::cmd_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full  = count == 2'd2;
  assign valid = count != 2'd0;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

endmodule

`default_nettype wire

### src/gsr0_back.sv
// Back end: calibration state, run sequencer and output register.
// Depends on gsr0_pkg and gsr0_div.
`default_nettype none

module gsr0_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire gsr0_pkg::cfg_t  cfg,
  input  wire logic            fifo_valid,
  input  wire gsr0_pkg::cmd_t  fifo_cmd,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output gsr0_pkg::out_t       out_data
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_AVG_GO   = 4'd1;
  localparam logic [3:0] S_AVG_WAIT = 4'd2;
  localparam logic [3:0] S_CHK      = 4'd3;
  localparam logic [3:0] S_RS_GO    = 4'd4;
  localparam logic [3:0] S_RS_WAIT  = 4'd5;
  localparam logic [3:0] S_R0_GO    = 4'd6;
  localparam logic [3:0] S_R0_WAIT  = 4'd7;
  localparam logic [3:0] S_RANGE    = 4'd8;

  logic [3:0]  state;
  logic        running;
  logic [19:0] vsum;
  logic [7:0]  taken;
  logic [15:0] r0;
  logic [11:0] avg;
  logic [28:0] prod;
  logic [15:0] rs;
  logic [15:0] r0c;

  logic [7:0]  need;
  logic [19:0] sum_next;
  logic [7:0]  taken_next;
  logic        slot_free;
  logic [19:0] avg_raw;
  logic [11:0] avg_clamped;
  logic        in_range;
  logic        last_sample;
  logic        avg_neg;
  logic        result_now;

  gsr0_pkg::div_req_t div_req;
  gsr0_pkg::div_rsp_t div_rsp;

  gsr0_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign need       = (cfg.sample_count == 8'd0) ? 8'd1 : cfg.sample_count;
  assign sum_next   = vsum + {8'd0, fifo_cmd.sample_mv};
  assign taken_next = taken + 8'd1;
  assign slot_free  = !out_valid || out_ready;
  assign pop        = (state == S_IDLE) && fifo_valid && slot_free;

  // sample that closes the open run
  assign last_sample = (fifo_cmd.op == gsr0_pkg::OP_SAMPLE) && running &&
                       (taken_next >= need);
  assign avg_neg     = {1'b0, avg} > cfg.supply_mv;
  // output register takes a new transaction this cycle
  assign result_now  = (pop && !last_sample) || ((state == S_CHK) && avg_neg) ||
                       (state == S_RANGE);

  assign avg_raw     = div_rsp.quotient[19:0];
  assign avg_clamped = (avg_raw > {8'd0, gsr0_pkg::AVG_MAX_MV}) ? gsr0_pkg::AVG_MAX_MV :
                       (avg_raw < {8'd0, gsr0_pkg::AVG_MIN_MV}) ? gsr0_pkg::AVG_MIN_MV :
                       avg_raw[11:0];
  assign in_range    = (r0c >= cfg.r0_min_q88) && (r0c <= cfg.r0_max_q88);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {vsum, 12'd0};
    div_req.divisor  = {8'd0, need};
    div_req.steps    = gsr0_pkg::AVG_DIV_STEPS;
    unique case (state)
      S_AVG_GO: div_req.start = 1'b1;
      S_RS_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {1'b0, prod, 2'b00};
        div_req.divisor  = {4'd0, avg};
        div_req.steps    = gsr0_pkg::RS_DIV_STEPS;
      end
      S_R0_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {rs, 16'd0};
        div_req.divisor  = cfg.clean_air_ratio_q88;
        div_req.steps    = gsr0_pkg::R0_DIV_STEPS;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      running   <= 1'b0;
      vsum      <= 20'd0;
      taken     <= 8'd0;
      r0        <= gsr0_pkg::R0_DEFAULT_Q88;
      out_valid <= 1'b0;
    end else begin
      if (result_now) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            out_data.avg_mv <= 12'd0;
            unique case (fifo_cmd.op)
              gsr0_pkg::OP_START: begin
                out_data.r0_q88 <= r0;
                if (running) begin
                  out_data.status <= gsr0_pkg::STAT_BUSY;
                end else begin
                  running         <= 1'b1;
                  vsum            <= 20'd0;
                  taken           <= 8'd0;
                  out_data.status <= gsr0_pkg::STAT_STARTED;
                end
              end
              gsr0_pkg::OP_SAMPLE: begin
                out_data.r0_q88 <= r0;
                if (!running) begin
                  out_data.status <= gsr0_pkg::STAT_IGNORED;
                end else begin
                  vsum  <= sum_next;
                  taken <= taken_next;
                  if (last_sample) begin
                    // last sample: result comes from the sequencer
                    running <= 1'b0;
                    state   <= S_AVG_GO;
                  end else begin
                    out_data.status <= gsr0_pkg::STAT_TAKEN;
                  end
                end
              end
              gsr0_pkg::OP_LOAD: begin
                r0              <= fifo_cmd.value;
                out_data.r0_q88 <= fifo_cmd.value;
                out_data.status <= gsr0_pkg::STAT_LOADED;
              end
              gsr0_pkg::OP_LOAD_DEF: begin
                r0              <= fifo_cmd.value;
                out_data.r0_q88 <= fifo_cmd.value;
                out_data.status <= gsr0_pkg::STAT_DEFAULT;
              end
              default: begin
                out_data.r0_q88 <= r0;
                out_data.status <= gsr0_pkg::STAT_IGNORED;
              end
            endcase
          end
        end
        S_AVG_GO: state <= S_AVG_WAIT;
        S_AVG_WAIT: begin
          if (div_rsp.done) begin
            avg   <= avg_clamped;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (avg_neg) begin
            // negative Rs: run ends, R0 kept
            out_data.status <= gsr0_pkg::STAT_OOR;
            out_data.r0_q88 <= r0;
            out_data.avg_mv <= avg;
            state           <= S_IDLE;
          end else begin
            prod  <= cfg.load_res_q88 * (cfg.supply_mv - {1'b0, avg});
            state <= S_RS_GO;
          end
        end
        S_RS_GO: state <= S_RS_WAIT;
        S_RS_WAIT: begin
          if (div_rsp.done) begin
            rs <= gsr0_pkg::sat16(div_rsp.quotient);
            if (cfg.clean_air_ratio_q88 == 16'd0) begin
              r0c   <= 16'hFFFF;
              state <= S_RANGE;
            end else begin
              state <= S_R0_GO;
            end
          end
        end
        S_R0_GO: state <= S_R0_WAIT;
        S_R0_WAIT: begin
          if (div_rsp.done) begin
            r0c   <= gsr0_pkg::sat16(div_rsp.quotient);
            state <= S_RANGE;
          end
        end
        S_RANGE: begin
          out_data.avg_mv <= avg;
          if (in_range) begin
            r0              <= r0c;
            out_data.r0_q88 <= r0c;
            out_data.status <= gsr0_pkg::STAT_CAL;
          end else begin
            out_data.r0_q88 <= r0;
            out_data.status <= gsr0_pkg::STAT_OOR;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/gas_sensor_r0_calibrator_top.sv
// Gas sensor R0 calibrator, top level: configuration registers and wiring.
// Depends on gsr0_pkg, gsr0_front, gsr0_fifo, gsr0_back and the assert header.
//
// Usage:
//  - Input channel in_valid/in_ready/in_data carries one transaction per item
//    (start, voltage sample, load stored R0). Output channel
//    out_valid/out_ready/out_data returns exactly one transaction per item.
//  - Config: cfg_we, cfg_idx, cfg_wdata write one register per cycle; indexes
//    beyond the register list are dropped. Write only while the block is idle.
//  - Start, load, ignored and non-final sample items reach out_valid through
//    the input register, the queue and the output register.
//  - The sample that completes a run goes through up to three passes of a shared
//    2-bit-per-cycle divider (average, Rs, R0; a negative Rs stops after the first,
//    a zero ratio skips R0) plus sequencer steps. That divider sets the rate for
//    run-ending samples; others sustain one per cycle while the back end is idle and unstalled.
//  - Up to two transactions wait in the queue, so the front keeps accepting
//    while the back computes or the receiver stalls; once the queue and the
//    input register fill, in_ready drops.
//  - Reset (rst, synchronous): registers return to their defaults, R0 = 10.0
//    kOhm, no run open, queue and output empty.
`default_nettype none
`include "gas_sensor_r0_calibrator_top_assert.svh"

module gas_sensor_r0_calibrator_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire gsr0_pkg::in_t                      in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output gsr0_pkg::out_t                          out_data,
  input  wire logic                               cfg_we,
  input  wire logic [gsr0_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [gsr0_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  gsr0_pkg::cfg_t cfg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_count        <= 8'd50;
      cfg.supply_mv           <= 13'd5000;
      cfg.load_res_q88        <= 16'd1306;
      cfg.clean_air_ratio_q88 <= 16'd2516;
      cfg.r0_min_q88          <= 16'd128;
      cfg.r0_max_q88          <= 16'd38400;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        gsr0_pkg::CFG_SAMPLE_COUNT: cfg.sample_count        <= cfg_wdata[7:0];
        gsr0_pkg::CFG_SUPPLY_MV:    cfg.supply_mv           <= cfg_wdata[12:0];
        gsr0_pkg::CFG_LOAD_RES:     cfg.load_res_q88        <= cfg_wdata;
        gsr0_pkg::CFG_RATIO:        cfg.clean_air_ratio_q88 <= cfg_wdata;
        gsr0_pkg::CFG_R0_MIN:       cfg.r0_min_q88          <= cfg_wdata;
        gsr0_pkg::CFG_R0_MAX:       cfg.r0_max_q88          <= cfg_wdata;
        default: ;  // unmapped index
      endcase
    end
  end

  logic           push;
  gsr0_pkg::cmd_t push_cmd;
  logic           fifo_full;
  logic           fifo_valid;
  gsr0_pkg::cmd_t fifo_cmd;
  logic           pop;
  logic           run_done_status;

  // accept and classify
  gsr0_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .fifo_full (fifo_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // decouples front from the long run-ending computation
  gsr0_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_cmd),
    .full  (fifo_full),
    .pop   (pop),
    .valid (fifo_valid),
    .dout  (fifo_cmd)
  );

  // execute and hold result
  gsr0_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .fifo_valid (fifo_valid),
    .fifo_cmd   (fifo_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // status of a transaction that closes a run
  assign run_done_status = (out_data.status == gsr0_pkg::STAT_CAL) ||
                           (out_data.status == gsr0_pkg::STAT_OOR);

  // queue is never overrun or underrun
  `GSR0_ASSERT_HOLDS(a_push_not_full, push, !fifo_full)
  `GSR0_ASSERT_HOLDS(a_pop_has_data, pop, fifo_valid)
  // every non-sample command yields a result on the next cycle
  `GSR0_ASSERT_NEXT(a_cmd_result, pop && (fifo_cmd.op != gsr0_pkg::OP_SAMPLE), out_valid)
  // average is reported only for finished runs
  `GSR0_ASSERT_HOLDS(a_avg_field, out_valid && !run_done_status, out_data.avg_mv == 12'd0)

endmodule

`default_nettype wire

### tb/gas_sensor_r0_calibrator_top_test.sv
// Self-checking testbench for gas_sensor_r0_calibrator_top.
// Depends on gsr0_pkg and the calibrator RTL. An in-bench predictor computes each
// transaction's status, R0 and average, and a clocked monitor checks them in order.
`default_nettype none

module gas_sensor_r0_calibrator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // mode 3 has no name in the package; the block treats it as a no-op
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // The quiet limit covers a run-ending sample, a long receiver stall, the forced
  // hold-off and a few queued run-ending samples, and leaves plenty of margin.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int HOLD_OFF       = 300;

  // DUT ports, all inputs driven to known values from time zero
  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  gsr0_pkg::in_t                   in_data   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  gsr0_pkg::out_t                  out_data;
  logic                            cfg_we    = 1'b0;
  logic [gsr0_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [gsr0_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  gas_sensor_r0_calibrator_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the register file. It starts at the reset defaults.
  gsr0_pkg::cfg_t cal_cfg = '{sample_count: 8'd50, supply_mv: 13'd5000,
                              load_res_q88: 16'd1306, clean_air_ratio_q88: 16'd2516,
                              r0_min_q88: 16'd128, r0_max_q88: 16'd38400};

  // Shadow of the calibrator state
  logic [15:0] r0_now   = gsr0_pkg::R0_DEFAULT_Q88;
  logic        run_open = 1'b0;
  logic [19:0] mv_sum   = '0;
  logic [7:0]  n_taken  = '0;

  gsr0_pkg::in_t  sensor_items[$];     // items waiting for the driver
  gsr0_pkg::out_t r0_results_due[$];   // predicted results, oldest first
  gsr0_pkg::out_t due_result;

  int errors       = 0;
  bit no_idle      = 1'b0;   // when set, neither side inserts gaps
  int hold_request = 0;      // set by the stimulus; the receiver loads it into hold_left
  int hold_taken   = 0;      // last request the receiver has loaded
  int hold_left    = 0;
  int stall_left   = 0;
  int send_gap     = 0;
  int quiet_cycles = 0;

  initial forever #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: the effect of one accepted item on the calibrator state, and the
  // result transaction that it produces.
  // ---------------------------------------------------------------------------
  function automatic gsr0_pkg::out_t calibrator_step(gsr0_pkg::in_t item);
    gsr0_pkg::out_t res;
    logic [7:0]     need;
    logic [19:0]    avg_full;
    logic [63:0]    rs;
    logic [63:0]    r0_calc;
    res.status = gsr0_pkg::STAT_IGNORED;
    res.avg_mv = '0;
    case (item.mode)
      gsr0_pkg::MODE_START: begin
        if (run_open) begin
          res.status = gsr0_pkg::STAT_BUSY;
        end else begin
          run_open   = 1'b1;
          mv_sum     = '0;
          n_taken    = '0;
          res.status = gsr0_pkg::STAT_STARTED;
        end
      end
      gsr0_pkg::MODE_SAMPLE: begin
        if (run_open) begin
          // a count of zero behaves as one
          need       = (cal_cfg.sample_count == 8'd0) ? 8'd1 : cal_cfg.sample_count;
          mv_sum     = mv_sum + 20'(item.sample_mv);
          n_taken    = n_taken + 8'd1;
          res.status = gsr0_pkg::STAT_TAKEN;
          // >= so that a count lowered during a run ends it on the next sample
          if (n_taken >= need) begin
            avg_full = mv_sum / 20'(need);
            if (avg_full > 20'(gsr0_pkg::AVG_MAX_MV)) avg_full = 20'(gsr0_pkg::AVG_MAX_MV);
            if (avg_full < 20'(gsr0_pkg::AVG_MIN_MV)) avg_full = 20'(gsr0_pkg::AVG_MIN_MV);
            res.avg_mv = avg_full[11:0];
            res.status = gsr0_pkg::STAT_OOR;
            // a supply below the average would make Rs negative: the run fails
            if (20'(cal_cfg.supply_mv) >= avg_full) begin
              rs = 64'(cal_cfg.load_res_q88) * (64'(cal_cfg.supply_mv) - 64'(avg_full))
                   / 64'(avg_full);
              if (rs > 64'd65535) rs = 64'd65535;
              if (cal_cfg.clean_air_ratio_q88 == 16'd0) begin
                r0_calc = 64'd65535;
              end else begin
                r0_calc = (rs << 8) / 64'(cal_cfg.clean_air_ratio_q88);
                if (r0_calc > 64'd65535) r0_calc = 64'd65535;
              end
              // inclusive window; when min is above max nothing passes
              if (r0_calc >= 64'(cal_cfg.r0_min_q88) && r0_calc <= 64'(cal_cfg.r0_max_q88)) begin
                r0_now     = r0_calc[15:0];
                res.status = gsr0_pkg::STAT_CAL;
              end
            end
            run_open = 1'b0;
          end
        end
      end
      gsr0_pkg::MODE_LOAD: begin
        // a load is allowed during a run and leaves the run open
        if (item.stored_r0_q88 == 16'd0) begin
          r0_now     = gsr0_pkg::R0_DEFAULT_Q88;
          res.status = gsr0_pkg::STAT_DEFAULT;
        end else begin
          r0_now     = item.stored_r0_q88;
          res.status = gsr0_pkg::STAT_LOADED;
        end
      end
      default: ;  // unused mode: ignored, state untouched
    endcase
    res.r0_q88 = r0_now;
    return res;
  endfunction

  // Gap length in cycles: mostly zero or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued items and predicts the result of each accepted
  // transaction. Valid stays high with a stable payload until it is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) r0_results_due.push_back(calibrator_step(in_data));
      if (!in_valid || in_ready) begin
        if (send_gap > 0 || sensor_items.size() == 0) begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end else begin
          in_data  <= sensor_items.pop_front();
          in_valid <= 1'b1;
          send_gap = no_idle ? 0 : pick_gap();
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned due, int unsigned seen);
    if (due != seen) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, due, seen);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transaction against the oldest prediction and
  // drives out_ready. A hold-off request keeps ready low for a long stretch so
  // that the block backs up and drops in_ready.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (r0_results_due.size() == 0) begin
          errors++;
          $display("%0t ns: result transaction, expected none, actual status %0d r0 %0d avg %0d",
                   $time, out_data.status, out_data.r0_q88, out_data.avg_mv);
        end else begin
          due_result = r0_results_due.pop_front();
          check_field("status", due_result.status, out_data.status);
          check_field("r0_q88", due_result.r0_q88, out_data.r0_q88);
          check_field("avg_mv", due_result.avg_mv, out_data.avg_mv);
        end
      end
      if (hold_request != hold_taken) begin
        hold_left  = hold_request;
        hold_taken = hold_request;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready  <= 1'b1;
        stall_left = no_idle ? 0 : pick_gap();
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, quiet_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(logic [1:0] mode, logic [11:0] mv, logic [15:0] stored);
    gsr0_pkg::in_t item;
    item.mode          = mode;
    item.sample_mv     = mv;
    item.stored_r0_q88 = stored;
    sensor_items.push_back(item);
  endtask

  function automatic logic [15:0] rand_stored();
    return ($urandom_range(6) == 0) ? 16'd0 : 16'($urandom);
  endfunction

  // Idle means nothing queued, nothing offered and nothing outstanding.
  task automatic wait_idle();
    while (sensor_items.size() != 0 || in_valid || r0_results_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes one register. The caller lowers cfg_we after its last write, so
  // back-to-back writes keep the enable high.
  task automatic set_reg(logic [gsr0_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    case (idx)
      gsr0_pkg::CFG_SAMPLE_COUNT: cal_cfg.sample_count        = value[7:0];
      gsr0_pkg::CFG_SUPPLY_MV:    cal_cfg.supply_mv           = value[12:0];
      gsr0_pkg::CFG_LOAD_RES:     cal_cfg.load_res_q88        = value;
      gsr0_pkg::CFG_RATIO:        cal_cfg.clean_air_ratio_q88 = value;
      gsr0_pkg::CFG_R0_MIN:       cal_cfg.r0_min_q88          = value;
      gsr0_pkg::CFG_R0_MAX:       cal_cfg.r0_max_q88          = value;
      default: ;
    endcase
  endtask

  task automatic apply_cfg(int count, int supply, int load, int ratio, int lo, int hi);
    set_reg(gsr0_pkg::CFG_SAMPLE_COUNT, 16'(count));
    set_reg(gsr0_pkg::CFG_SUPPLY_MV, 16'(supply));
    set_reg(gsr0_pkg::CFG_LOAD_RES, 16'(load));
    set_reg(gsr0_pkg::CFG_RATIO, 16'(ratio));
    set_reg(gsr0_pkg::CFG_R0_MIN, 16'(lo));
    set_reg(gsr0_pkg::CFG_R0_MAX, 16'(hi));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // A start followed by samples drawn around a random level; the spread runs
  // from a flat signal up to the full scale. A load may be slipped in mid-run.
  task automatic queue_run(int samples, bit with_load);
    int base;
    int w;
    int lo;
    int hi;
    int cut;
    base = $urandom_range(4095);
    case ($urandom_range(3))
      0:       w = 0;
      1:       w = 20;
      2:       w = 300;
      default: w = 4095;
    endcase
    lo  = (base > w) ? base - w : 0;
    hi  = (base + w > 4095) ? 4095 : base + w;
    cut = with_load ? $urandom_range(samples - 1, 0) : -1;
    queue_item(gsr0_pkg::MODE_START, 12'($urandom), rand_stored());
    for (int i = 0; i < samples; i++) begin
      if (i == cut) queue_item(gsr0_pkg::MODE_LOAD, 12'($urandom), rand_stored());
      queue_item(gsr0_pkg::MODE_SAMPLE, 12'($urandom_range(hi, lo)), 16'($urandom));
    end
  endtask

  // Mostly complete runs. The rest is loads, stray samples, double starts,
  // unused modes and runs cut short.
  task automatic random_phase(int budget);
    int made;
    int r;
    int need;
    int k;
    made = 0;
    while (made < budget) begin
      need = (cal_cfg.sample_count == 8'd0) ? 1 : int'(cal_cfg.sample_count);
      r    = $urandom_range(99);
      if (r < 60) begin
        queue_run(need, $urandom_range(9) == 0);
        made += need + 1;
      end else if (r < 70) begin
        queue_item(gsr0_pkg::MODE_LOAD, 12'($urandom), rand_stored());
        made++;
      end else if (r < 77) begin
        queue_item(MODE_UNUSED, 12'($urandom), 16'($urandom));  // not counted
      end else if (r < 87) begin
        queue_item(gsr0_pkg::MODE_SAMPLE, 12'($urandom), 16'($urandom));
        made++;
      end else if (r < 93) begin
        queue_item(gsr0_pkg::MODE_START, 12'($urandom), 16'($urandom));
        made++;
      end else begin
        k = $urandom_range(need - 1, 0);
        queue_item(gsr0_pkg::MODE_START, 12'($urandom), 16'($urandom));
        for (int i = 0; i < k; i++) begin
          queue_item(gsr0_pkg::MODE_SAMPLE, 12'($urandom), 16'($urandom));
        end
        made += k + 1;
      end
    end
  endtask

  // Random register set, weighted toward the edges of each range
  task automatic random_cfg(bit long_runs);
    int count;
    int supply;
    int load;
    int ratio;
    int lo;
    int hi;
    count = long_runs ? 255 : (($urandom_range(19) == 0) ? 0 : $urandom_range(6, 1));
    case ($urandom_range(5))
      0:       supply = 0;
      1:       supply = 8191;
      2:       supply = 5000;
      default: supply = $urandom_range(8191, 1000);
    endcase
    case ($urandom_range(5))
      0:       load = 0;
      1:       load = 65535;
      default: load = $urandom_range(4000, 200);
    endcase
    case ($urandom_range(6))
      0:       ratio = 0;
      1:       ratio = 1;
      2:       ratio = 65535;
      default: ratio = $urandom_range(5000, 500);
    endcase
    case ($urandom_range(5))
      0:       lo = 0;
      1:       lo = 65535;
      default: lo = $urandom_range(1000);
    endcase
    case ($urandom_range(5))
      0:       hi = 65535;
      1:       hi = 0;
      default: hi = $urandom_range(65535, 2000);
    endcase
    apply_cfg(count, supply, load, ratio, lo, hi);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset defaults: ignored items, loads of zero and full scale, refused start
    queue_item(MODE_UNUSED, 12'hFFF, 16'hFFFF);
    queue_item(gsr0_pkg::MODE_SAMPLE, 12'd1234, 16'd0);   // no run open: ignored
    queue_item(gsr0_pkg::MODE_LOAD, 12'd0, 16'd0);        // falls back to 10.0 kOhm
    queue_item(gsr0_pkg::MODE_LOAD, 12'hFFF, 16'hFFFF);
    queue_item(gsr0_pkg::MODE_LOAD, 12'd0, 16'd1);
    queue_item(gsr0_pkg::MODE_START, 12'd0, 16'd0);
    queue_item(gsr0_pkg::MODE_START, 12'd0, 16'd0);       // busy
    queue_item(gsr0_pkg::MODE_LOAD, 12'd0, 16'd0);        // load during a run
    queue_item(MODE_UNUSED, 12'd0, 16'd0);
    wait_idle();

    // Run still open; short runs that clamp the average at both ends
    apply_cfg(2, 5000, 1306, 2516, 128, 38400);
    queue_item(gsr0_pkg::MODE_SAMPLE, 12'hFFF, 16'hFFFF);
    queue_item(gsr0_pkg::MODE_SAMPLE, 12'hFFF, 16'd0);
    queue_item(gsr0_pkg::MODE_START, 12'd0, 16'd0);
    queue_item(gsr0_pkg::MODE_SAMPLE, 12'd0, 16'd0);
    queue_item(gsr0_pkg::MODE_SAMPLE, 12'd0, 16'd0);
    wait_idle();

    // Supply below the average: Rs would be negative
    apply_cfg(1, 0, 1306, 2516, 128, 38400);
    queue_item(gsr0_pkg::MODE_START, 12'd0, 16'd0);
    queue_item(gsr0_pkg::MODE_SAMPLE, 12'd1000, 16'd0);
    wait_idle();

    // Zero ratio saturates R0, then passes the widest window
    apply_cfg(1, 8191, 65535, 0, 0, 65535);
    queue_item(gsr0_pkg::MODE_START, 12'd0, 16'd0);
    queue_item(gsr0_pkg::MODE_SAMPLE, 12'd500, 16'd0);
    wait_idle();

    // Window with min above max rejects everything
    apply_cfg(1, 5000, 1306, 2516, 65535, 0);
    queue_item(gsr0_pkg::MODE_START, 12'd0, 16'd0);
    queue_item(gsr0_pkg::MODE_SAMPLE, 12'd2000, 16'd0);
    wait_idle();

    // Count lowered mid-run, down to zero (acts as one)
    apply_cfg(5, 5000, 0, 1, 0, 65535);
    queue_item(gsr0_pkg::MODE_START, 12'd0, 16'd0);
    queue_item(gsr0_pkg::MODE_SAMPLE, 12'd100, 16'd0);
    queue_item(gsr0_pkg::MODE_SAMPLE, 12'd2000, 16'd0);
    queue_item(gsr0_pkg::MODE_SAMPLE, 12'd3000, 16'd0);
    wait_idle();
    apply_cfg(0, 5000, 0, 1, 0, 65535);
    queue_item(gsr0_pkg::MODE_SAMPLE, 12'd3000, 16'd0);
    wait_idle();

    // Random phases. Phase 1 runs with no gaps and a long receiver hold-off.
    // Phase 2 also runs with no gaps. Phase 4 uses the longest runs.
    for (int p = 0; p < 7; p++) begin
      random_cfg(p == 4);
      no_idle = (p == 1 || p == 2);
      if (p == 1) hold_request = HOLD_OFF;
      random_phase((p == 4) ? 256 : 125);
      wait_idle();
    end
    no_idle = 1'b0;

    // Let any stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && r0_results_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
